### src/rwmc_pkg.sv
package rwmc_pkg;

    // payload widths of the channels
    localparam int OP_W       = 2;
    localparam int DIR_W      = 2;
    localparam int POS_W      = 6;
    localparam int WALL_W     = 4;
    localparam int CELL_W     = 5;
    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // width used to compare grid sizes against the largest grid
    localparam int CMP_W = 9;

    typedef enum logic [OP_W-1:0] {
        OP_STEP    = 2'd0,
        OP_READ    = 2'd1,
        OP_RESTART = 2'd2,
        OP_IDLE    = 2'd3
    } t_op;

    typedef enum logic [DIR_W-1:0] {
        DIR_WEST  = 2'd0,
        DIR_SOUTH = 2'd1,
        DIR_EAST  = 2'd2,
        DIR_NORTH = 2'd3
    } t_dir;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS      = 2'd0,
        CFG_COLS      = 2'd1,
        CFG_START_ROW = 2'd2,
        CFG_START_COL = 2'd3
    } t_cfg_idx;

    // cell layout: west, south, east, north walls, then the unvisited mark
    localparam logic [CELL_W-1:0] CELL_FRESH    = 5'h1F;
    localparam logic [CELL_W-1:0] UNVISITED_BIT = 5'h10;
    localparam logic [CELL_W-1:0] START_CELL    = 5'h0F;
    localparam logic [CELL_W-1:0] WALL_WEST     = 5'h01;
    localparam logic [CELL_W-1:0] WALL_SOUTH    = 5'h02;
    localparam logic [CELL_W-1:0] WALL_EAST     = 5'h04;
    localparam logic [CELL_W-1:0] WALL_NORTH    = 5'h08;

    localparam logic [WALL_W-1:0] WALLS_CLOSED = 4'hF;

    localparam logic [SIZE_W-1:0] RST_ROWS  = 7'd16;
    localparam logic [SIZE_W-1:0] RST_COLS  = 7'd16;
    localparam logic [POS_W-1:0]  RST_START = 6'd0;

    function automatic logic [CELL_W-1:0] here_wall(input t_dir d);
        logic [CELL_W-1:0] w;
        case (d)
            DIR_WEST:  w = WALL_WEST;
            DIR_SOUTH: w = WALL_SOUTH;
            DIR_EAST:  w = WALL_EAST;
            default:   w = WALL_NORTH;
        endcase
        return w;
    endfunction

    function automatic logic [CELL_W-1:0] there_wall(input t_dir d);
        logic [CELL_W-1:0] w;
        case (d)
            DIR_WEST:  w = WALL_EAST;
            DIR_SOUTH: w = WALL_NORTH;
            DIR_EAST:  w = WALL_WEST;
            default:   w = WALL_SOUTH;
        endcase
        return w;
    endfunction

    typedef struct packed {
        logic take_item;
        logic restart;
        logic sweep;
        logic rd_item;
        logic rd_there;
        logic rd_here;
        logic wr_there;
        logic wr_here;
        logic capture_read;
        logic carve;
        logic move;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic finished;
        logic same_cell;
        logic there_unvis;
        logic sweep_last;
        logic out_busy;
    } t_status;

endpackage

### src/rwmc_if.sv
interface rwmc_in_if;
    logic                        valid;
    logic                        ready;
    logic [rwmc_pkg::OP_W-1:0]   operation;
    logic [rwmc_pkg::DIR_W-1:0]  direction;
    logic [rwmc_pkg::POS_W-1:0]  read_row;
    logic [rwmc_pkg::POS_W-1:0]  read_col;

    modport source(output valid, operation, direction, read_row, read_col, input ready);
    modport sink(input valid, operation, direction, read_row, read_col, output ready);
endinterface

interface rwmc_out_if;
    logic                         valid;
    logic                         ready;
    logic [rwmc_pkg::POS_W-1:0]   walker_row;
    logic [rwmc_pkg::POS_W-1:0]   walker_col;
    logic                         carved;
    logic                         finished;
    logic [rwmc_pkg::WALL_W-1:0]  cell_walls;
    logic                         cell_unvisited;

    modport source(output valid, walker_row, walker_col, carved, finished, cell_walls,
                   cell_unvisited, input ready);
    modport sink(input valid, walker_row, walker_col, carved, finished, cell_walls,
                 cell_unvisited, output ready);
endinterface

interface rwmc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rwmc_pkg::CFG_IDX_W-1:0]   index;
    logic [rwmc_pkg::CFG_DATA_W-1:0]  data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

### src/rwmc_ram.sv
module rwmc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/rwmc_ctrl.sv
module rwmc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  rwmc_pkg::t_status i_status,
    output logic              o_in_ready,
    output rwmc_pkg::t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_INIT   = 7'b0000001,
        S_CLEAR  = 7'b0000010,
        S_IDLE   = 7'b0000100,
        S_LOOK   = 7'b0001000,
        S_FETCH  = 7'b0010000,
        S_MODIFY = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.restart = 1'b1;
                n_pend        = 1'b0;
                n_state       = S_CLEAR;
            end
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = r_pend ? S_DONE : S_IDLE;
                    n_pend  = 1'b0;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = S_LOOK;
                end
            end
            S_LOOK: begin
                case (i_status.op)
                    rwmc_pkg::OP_RESTART: begin
                        o_cmd.restart = 1'b1;
                        n_pend        = 1'b1;
                        n_state       = S_CLEAR;
                    end
                    rwmc_pkg::OP_READ: begin
                        o_cmd.rd_item = 1'b1;
                        n_state       = S_FETCH;
                    end
                    rwmc_pkg::OP_STEP: begin
                        if (!i_status.finished && !i_status.same_cell) begin
                            o_cmd.rd_there = 1'b1;
                            n_state        = S_FETCH;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_FETCH: begin
                if (i_status.op == rwmc_pkg::OP_READ) begin
                    o_cmd.capture_read = 1'b1;
                    n_state            = S_DONE;
                end else if (i_status.there_unvis) begin
                    o_cmd.wr_there = 1'b1;
                    o_cmd.rd_here  = 1'b1;
                    o_cmd.carve    = 1'b1;
                    n_state        = S_MODIFY;
                end else begin
                    o_cmd.move = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_MODIFY: begin
                o_cmd.wr_here = 1'b1;
                o_cmd.move    = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule

### src/rwmc_dp.sv
module rwmc_dp #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rwmc_pkg::t_cmd                  i_cmd,
    output rwmc_pkg::t_status               o_status,
    input  logic [rwmc_pkg::OP_W-1:0]       i_operation,
    input  logic [rwmc_pkg::DIR_W-1:0]      i_direction,
    input  logic [rwmc_pkg::POS_W-1:0]      i_read_row,
    input  logic [rwmc_pkg::POS_W-1:0]      i_read_col,
    rwmc_cfg_if.sink                        i_cfg,
    rwmc_out_if.source                      o_out
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RSW   = $clog2(MAX_ROWS + 1);
    localparam int CSW   = $clog2(MAX_COLS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = MAX_ROWS * (1 << CW);
    localparam int TW    = RSW + CSW;
    localparam int VW    = $clog2(MAX_ROWS * MAX_COLS + 1);
    localparam int CMPW  = rwmc_pkg::CMP_W;

    // grid size from a register: zero acts as one, large values saturate
    function automatic logic [CMPW-1:0] clamp_size(input logic [rwmc_pkg::SIZE_W-1:0] v,
                                                   input logic [CMPW-1:0] maxv);
        logic [CMPW-1:0] r;
        if (v == '0) begin
            r = CMPW'(1);
        end else if (CMPW'(v) > maxv) begin
            r = maxv;
        end else begin
            r = CMPW'(v);
        end
        return r;
    endfunction

    logic [rwmc_pkg::SIZE_W-1:0]  r_cfg_rows, r_cfg_cols;
    logic [rwmc_pkg::POS_W-1:0]   r_cfg_start_row, r_cfg_start_col;

    logic [RSW-1:0]   r_grid_rows;
    logic [CSW-1:0]   r_grid_cols;
    logic [TW-1:0]    r_total;
    logic [RW-1:0]    r_walker_row;
    logic [CW-1:0]    r_walker_col;
    logic [VW-1:0]    r_visited;
    logic [AW-1:0]    r_sweep;

    logic [rwmc_pkg::OP_W-1:0]   r_op;
    logic [rwmc_pkg::DIR_W-1:0]  r_dir;
    logic [rwmc_pkg::POS_W-1:0]  r_rd_row, r_rd_col;
    logic                        r_carved;
    logic [rwmc_pkg::WALL_W-1:0] r_walls;
    logic                        r_unvis;

    logic                        r_out_valid;
    logic [rwmc_pkg::POS_W-1:0]  r_out_row, r_out_col;
    logic                        r_out_carved, r_out_finished;
    logic [rwmc_pkg::WALL_W-1:0] r_out_walls;
    logic                        r_out_unvis;

    logic [CMPW-1:0]  g_rows, g_cols;
    logic [RW-1:0]    start_row;
    logic [CW-1:0]    start_col;
    logic [RW-1:0]    nb_row;
    logic [CW-1:0]    nb_col;
    logic [AW-1:0]    here_addr, there_addr, item_addr;
    logic [rwmc_pkg::CELL_W-1:0] hw, tw;
    logic             finished, in_grid;

    logic                        ram_wr_en, ram_rd_en;
    logic [AW-1:0]               ram_wr_addr, ram_rd_addr;
    logic [rwmc_pkg::CELL_W-1:0] ram_wr_data, ram_rd_data;

    // grid and start position taken at restart
    always_comb begin
        g_rows = clamp_size(r_cfg_rows, CMPW'(MAX_ROWS));
        g_cols = clamp_size(r_cfg_cols, CMPW'(MAX_COLS));
        start_row = (CMPW'(r_cfg_start_row) < g_rows) ? RW'(r_cfg_start_row)
                                                       : RW'(g_rows - 1'b1);
        start_col = (CMPW'(r_cfg_start_col) < g_cols) ? CW'(r_cfg_start_col)
                                                       : CW'(g_cols - 1'b1);
    end

    // neighbor of the walker, clamped at the grid edges
    always_comb begin
        nb_row = r_walker_row;
        nb_col = r_walker_col;
        case (rwmc_pkg::t_dir'(r_dir))
            rwmc_pkg::DIR_WEST: begin
                if (r_walker_col != '0) nb_col = r_walker_col - 1'b1;
            end
            rwmc_pkg::DIR_SOUTH: begin
                if ((RSW'(r_walker_row) + RSW'(1)) < r_grid_rows) nb_row = r_walker_row + 1'b1;
            end
            rwmc_pkg::DIR_EAST: begin
                if ((CSW'(r_walker_col) + CSW'(1)) < r_grid_cols) nb_col = r_walker_col + 1'b1;
            end
            rwmc_pkg::DIR_NORTH: begin
                if (r_walker_row != '0) nb_row = r_walker_row - 1'b1;
            end
            default: ;
        endcase
    end

    assign hw         = rwmc_pkg::here_wall(rwmc_pkg::t_dir'(r_dir));
    assign tw         = rwmc_pkg::there_wall(rwmc_pkg::t_dir'(r_dir));
    assign here_addr  = {r_walker_row, r_walker_col};
    assign there_addr = {nb_row, nb_col};
    assign item_addr  = {RW'(r_rd_row), CW'(r_rd_col)};
    assign finished   = TW'(r_visited) >= r_total;
    assign in_grid    = (CMPW'(r_rd_row) < CMPW'(r_grid_rows)) &&
                        (CMPW'(r_rd_col) < CMPW'(r_grid_cols));

    // single write port: clearing sweep, then the two wall updates of a carve
    always_comb begin
        ram_wr_en   = i_cmd.sweep | i_cmd.wr_there | i_cmd.wr_here;
        ram_wr_addr = r_sweep;
        ram_wr_data = (r_sweep == here_addr) ? rwmc_pkg::START_CELL : rwmc_pkg::CELL_FRESH;
        if (i_cmd.wr_there) begin
            ram_wr_addr = there_addr;
            ram_wr_data = ram_rd_data & ~(rwmc_pkg::UNVISITED_BIT | tw);
        end else if (i_cmd.wr_here) begin
            ram_wr_addr = here_addr;
            ram_wr_data = ram_rd_data & ~hw;
        end
        ram_rd_en   = i_cmd.rd_item | i_cmd.rd_there | i_cmd.rd_here;
        ram_rd_addr = here_addr;
        if (i_cmd.rd_item) begin
            ram_rd_addr = item_addr;
        end else if (i_cmd.rd_there) begin
            ram_rd_addr = there_addr;
        end
    end

    rwmc_ram #(
        .WIDTH(rwmc_pkg::CELL_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(ram_rd_data)
    );

    always_comb begin
        o_status.op          = rwmc_pkg::t_op'(r_op);
        o_status.finished    = finished;
        o_status.same_cell   = (there_addr == here_addr);
        o_status.there_unvis = (ram_rd_data & rwmc_pkg::UNVISITED_BIT) != '0;
        o_status.sweep_last  = (r_sweep == AW'(DEPTH - 1));
        o_status.out_busy    = r_out_valid && !o_out.ready;
    end

    // configuration registers, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows      <= rwmc_pkg::RST_ROWS;
            r_cfg_cols      <= rwmc_pkg::RST_COLS;
            r_cfg_start_row <= rwmc_pkg::RST_START;
            r_cfg_start_col <= rwmc_pkg::RST_START;
        end else if (i_cfg.valid) begin
            case (rwmc_pkg::t_cfg_idx'(i_cfg.index))
                rwmc_pkg::CFG_ROWS:      r_cfg_rows      <= i_cfg.data;
                rwmc_pkg::CFG_COLS:      r_cfg_cols      <= i_cfg.data;
                rwmc_pkg::CFG_START_ROW: r_cfg_start_row <= i_cfg.data[rwmc_pkg::POS_W-1:0];
                rwmc_pkg::CFG_START_COL: r_cfg_start_col <= i_cfg.data[rwmc_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        r_total <= TW'(r_grid_rows) * TW'(r_grid_cols);
        if (i_cmd.restart) begin
            r_grid_rows  <= RSW'(g_rows);
            r_grid_cols  <= CSW'(g_cols);
            r_walker_row <= start_row;
            r_walker_col <= start_col;
            r_visited    <= VW'(1);
            r_sweep      <= '0;
        end else begin
            if (i_cmd.sweep) r_sweep <= r_sweep + 1'b1;
            if (i_cmd.carve) r_visited <= r_visited + 1'b1;
            if (i_cmd.move) begin
                r_walker_row <= nb_row;
                r_walker_col <= nb_col;
            end
        end
    end

    // item payload and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_op     <= i_operation;
            r_dir    <= i_direction;
            r_rd_row <= i_read_row;
            r_rd_col <= i_read_col;
            r_carved <= 1'b0;
            r_walls  <= '0;
            r_unvis  <= 1'b0;
        end else begin
            if (i_cmd.carve) r_carved <= 1'b1;
            if (i_cmd.capture_read) begin
                if (in_grid) begin
                    r_walls <= ram_rd_data[rwmc_pkg::WALL_W-1:0];
                    r_unvis <= ram_rd_data[rwmc_pkg::CELL_W-1];
                end else begin
                    r_walls <= rwmc_pkg::WALLS_CLOSED;
                    r_unvis <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_row      <= rwmc_pkg::POS_W'(r_walker_row);
            r_out_col      <= rwmc_pkg::POS_W'(r_walker_col);
            r_out_carved   <= r_carved;
            r_out_finished <= finished;
            r_out_walls    <= r_walls;
            r_out_unvis    <= r_unvis;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.walker_row     = r_out_row;
    assign o_out.walker_col     = r_out_col;
    assign o_out.carved         = r_out_carved;
    assign o_out.finished       = r_out_finished;
    assign o_out.cell_walls     = r_out_walls;
    assign o_out.cell_unvisited = r_out_unvis;

endmodule

### src/random_walk_maze_carver_top.sv
// random walk maze carver: builds a spanning-tree maze over a grid of cells
// input channel i_in: one beat per operation (walk step, cell read, restart)
// output channel o_out: exactly one beat per input beat, in order
// config channel i_cfg: grid rows, grid columns, start row, start column;
//   always ready, values take effect at the next restart
// steps per item, from the accepting edge up to the load of the output register:
//   a carving step reads the neighbor, writes the neighbor while reading its own cell,
//   then writes its own cell; a step into a visited cell reads the neighbor and moves;
//   a cell read reads the cell; a step against an edge, a step after the finish and an
//   unused op code go straight to the result; restart runs the clearing sweep; the cell
//   memory has one write and one read port; i_in is ready only between items
// restart sweeps every memory word, one per cycle, writing closed walls
//   and the unvisited mark, start cell already visited
// reset (synchronous, active low) loads default config and runs the same sweep;
//   i_in stays not ready until the sweep has ended, no result beat
// the output register holds a result until taken; the next input beat is
//   accepted meanwhile, but its result waits while o_out stays stalled
module random_walk_maze_carver_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rwmc_in_if.sink      i_in,
    rwmc_out_if.source   o_out,
    rwmc_cfg_if.sink     i_cfg
);

    // command and status between sequencer and datapath
    rwmc_pkg::t_cmd    cmd;
    rwmc_pkg::t_status status;
    logic              in_ready;

    assign i_in.ready = in_ready;

    // sequencer: clear sweep, step/read phases, result hand-off
    rwmc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .i_status  (status),
        .o_in_ready(in_ready),
        .o_cmd     (cmd)
    );

    // datapath: config registers, walker, cell store, output register
    rwmc_dp #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_operation(i_in.operation),
        .i_direction(i_in.direction),
        .i_read_row (i_in.read_row),
        .i_read_col (i_in.read_col),
        .i_cfg      (i_cfg),
        .o_out      (o_out)
    );

endmodule
